[design/bgc_pkg.sv]
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types, constants and helpers of the button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

  localparam int TickBits  = 16;
  localparam int CfgBits   = 16;
  localparam int CmpBits   = (TickBits > CfgBits) ? TickBits : CfgBits;
  localparam int ClickBits = 8;
  localparam int EventNum  = 10;
  localparam int CodeBits  = 4;
  localparam int IdxBits   = 4;

  typedef logic [TickBits-1:0]  tick_t;
  typedef logic [CfgBits-1:0]   cfg_word_t;
  typedef logic [CmpBits-1:0]   cmp_t;
  typedef logic [ClickBits-1:0] click_t;
  typedef logic [EventNum-1:0]  events_t;

  typedef enum logic [IdxBits-1:0] {
    RegActiveLevel = 4'd0,
    RegClickTicks  = 4'd1,
    RegPressTicks  = 4'd2,
    RegLongTicks   = 4'd3,
    RegTimeout     = 4'd4,
    RegMultiGap    = 4'd5,
    RegRepeatStart = 4'd6,
    RegRepeatPer   = 4'd7
  } reg_idx_e;

  typedef enum logic [CodeBits-1:0] {
    EvNone       = 4'd0,
    EvClick      = 4'd1,
    EvDouble     = 4'd2,
    EvMulti      = 4'd3,
    EvPress      = 4'd4,
    EvLong       = 4'd5,
    EvTimeout    = 4'd6,
    EvHold       = 4'd7,
    EvLongRel    = 4'd8,
    EvPressRel   = 4'd9,
    EvClickRel   = 4'd10
  } event_code_e;

  typedef struct packed {
    logic      active_level;
    cfg_word_t click_ticks;
    cfg_word_t press_ticks;
    cfg_word_t long_press_ticks;
    cfg_word_t timeout_ticks;
    cfg_word_t multi_click_gap;
    cfg_word_t repeat_start_ticks;
    cfg_word_t repeat_period;
  } cfg_t;

  typedef struct packed {
    event_code_e code;
    events_t     pending;
  } result_t;

  function automatic tick_t sat_inc(input tick_t v);
    sat_inc = (v == {TickBits{1'b1}}) ? v : v + tick_t'(1);
  endfunction

  function automatic cmp_t tick_ext(input tick_t v);
    tick_ext = cmp_t'(v);
  endfunction

  function automatic cmp_t cfg_ext(input cfg_word_t v);
    cfg_ext = cmp_t'(v);
  endfunction

  function automatic events_t ev_bit(input event_code_e c);
    ev_bit = events_t'(1) << (c - EvClick);
  endfunction

endpackage

[design/bgc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bgc_cfg_regs
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module bgc_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [bgc_pkg::IdxBits-1:0] cfg_index_i,
  input  bgc_pkg::cfg_word_t       cfg_data_i,
  output bgc_pkg::cfg_t            cfg_o
);

  bgc_pkg::cfg_t cfg_q;
  bgc_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (bgc_pkg::reg_idx_e'(cfg_index_i))
        bgc_pkg::RegActiveLevel: cfg_d.active_level       = cfg_data_i[0];
        bgc_pkg::RegClickTicks:  cfg_d.click_ticks        = cfg_data_i;
        bgc_pkg::RegPressTicks:  cfg_d.press_ticks        = cfg_data_i;
        bgc_pkg::RegLongTicks:   cfg_d.long_press_ticks   = cfg_data_i;
        bgc_pkg::RegTimeout:     cfg_d.timeout_ticks      = cfg_data_i;
        bgc_pkg::RegMultiGap:    cfg_d.multi_click_gap    = cfg_data_i;
        bgc_pkg::RegRepeatStart: cfg_d.repeat_start_ticks = cfg_data_i;
        bgc_pkg::RegRepeatPer:   cfg_d.repeat_period      = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_level       <= 1'b0;
      cfg_q.click_ticks        <= bgc_pkg::cfg_word_t'(5);
      cfg_q.press_ticks        <= bgc_pkg::cfg_word_t'(50);
      cfg_q.long_press_ticks   <= bgc_pkg::cfg_word_t'(200);
      cfg_q.timeout_ticks      <= bgc_pkg::cfg_word_t'(1000);
      cfg_q.multi_click_gap    <= bgc_pkg::cfg_word_t'(30);
      cfg_q.repeat_start_ticks <= bgc_pkg::cfg_word_t'(300);
      cfg_q.repeat_period      <= bgc_pkg::cfg_word_t'(20);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/bgc_tracker.sv]
// ----------------------------------------------------------------------------
// bgc_tracker
// Button status, tick counters, click burst and pending event mask; updated
// once per processed beat, with the pop of the lowest pending event when pop_i is set.
// ----------------------------------------------------------------------------
module bgc_tracker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              pin_i,
  input  logic              pop_i,
  input  bgc_pkg::cfg_t     cfg_i,
  output bgc_pkg::result_t  res_o
);

  logic               pushed_q, pushed_d;
  bgc_pkg::tick_t     pticks_q, pticks_d;
  bgc_pkg::tick_t     rticks_q, rticks_d;
  bgc_pkg::click_t    clicks_q, clicks_d;
  bgc_pkg::tick_t     div_q, div_d;
  bgc_pkg::events_t   flags_q, flags_d;

  logic               now_pushed;
  bgc_pkg::events_t   upd;
  bgc_pkg::events_t   lowest;
  logic [bgc_pkg::CodeBits-1:0] code;

  always_comb begin
    now_pushed = (pin_i == cfg_i.active_level);
    pushed_d   = now_pushed;
    pticks_d   = pticks_q;
    rticks_d   = rticks_q;
    clicks_d   = clicks_q;
    div_d      = div_q;
    upd        = flags_q;

    if (now_pushed && !pushed_q) begin
      if (bgc_pkg::tick_ext(rticks_q) > bgc_pkg::cfg_ext(cfg_i.multi_click_gap)) begin
        clicks_d = '0;
      end
      rticks_d = '0;
    end else if (!now_pushed && pushed_q) begin
      div_d = '0;
      if (bgc_pkg::tick_ext(pticks_q) > bgc_pkg::cfg_ext(cfg_i.timeout_ticks)) begin
        upd = flags_q;
      end else if (bgc_pkg::tick_ext(pticks_q) >
                   bgc_pkg::cfg_ext(cfg_i.long_press_ticks)) begin
        upd = upd | bgc_pkg::ev_bit(bgc_pkg::EvLongRel);
      end else if (bgc_pkg::tick_ext(pticks_q) > bgc_pkg::cfg_ext(cfg_i.press_ticks)) begin
        upd = upd | bgc_pkg::ev_bit(bgc_pkg::EvPressRel);
      end else if (bgc_pkg::tick_ext(pticks_q) > bgc_pkg::cfg_ext(cfg_i.click_ticks)) begin
        upd = upd | bgc_pkg::ev_bit(bgc_pkg::EvClickRel);
      end
      pticks_d = '0;
    end

    if (now_pushed) begin
      if (bgc_pkg::tick_ext(pticks_d) == bgc_pkg::cfg_ext(cfg_i.click_ticks)) begin
        if (clicks_d != {bgc_pkg::ClickBits{1'b1}}) begin
          clicks_d = clicks_d + bgc_pkg::click_t'(1);
        end
        if (clicks_d == bgc_pkg::click_t'(2)) begin
          upd = upd | bgc_pkg::ev_bit(bgc_pkg::EvDouble);
        end else if (clicks_d > bgc_pkg::click_t'(2)) begin
          upd = upd | bgc_pkg::ev_bit(bgc_pkg::EvMulti);
        end
        upd = upd | bgc_pkg::ev_bit(bgc_pkg::EvClick);
      end else if (bgc_pkg::tick_ext(pticks_d) == bgc_pkg::cfg_ext(cfg_i.press_ticks)) begin
        upd = upd | bgc_pkg::ev_bit(bgc_pkg::EvPress);
      end else if (bgc_pkg::tick_ext(pticks_d) ==
                   bgc_pkg::cfg_ext(cfg_i.long_press_ticks)) begin
        upd = upd | bgc_pkg::ev_bit(bgc_pkg::EvLong);
      end else if (bgc_pkg::tick_ext(pticks_d) ==
                   bgc_pkg::cfg_ext(cfg_i.timeout_ticks)) begin
        upd = upd | bgc_pkg::ev_bit(bgc_pkg::EvTimeout);
      end

      if (bgc_pkg::tick_ext(pticks_d) > bgc_pkg::cfg_ext(cfg_i.repeat_start_ticks)) begin
        if (bgc_pkg::tick_ext(div_d) > bgc_pkg::cfg_ext(cfg_i.repeat_period)) begin
          upd   = upd | bgc_pkg::ev_bit(bgc_pkg::EvHold);
          div_d = '0;
        end else begin
          div_d = bgc_pkg::sat_inc(div_d);
        end
      end
      pticks_d = bgc_pkg::sat_inc(pticks_d);
    end else begin
      rticks_d = bgc_pkg::sat_inc(rticks_d);
    end

    // isolate the lowest pending bit and encode it
    lowest = pop_i ? (upd & (~upd + bgc_pkg::events_t'(1))) : '0;
    code   = '0;
    for (int i = 0; i < bgc_pkg::EventNum; i++) begin
      if (lowest[i]) begin
        code = code | bgc_pkg::CodeBits'(i + 1);
      end
    end
    flags_d = upd & ~lowest;

    res_o.code    = bgc_pkg::event_code_e'(code);
    res_o.pending = flags_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pushed_q <= 1'b0;
      pticks_q <= '0;
      rticks_q <= '0;
      clicks_q <= '0;
      div_q    <= '0;
      flags_q  <= '0;
    end else if (fire_i) begin
      pushed_q <= pushed_d;
      pticks_q <= pticks_d;
      rticks_q <= rticks_d;
      clicks_q <= clicks_d;
      div_q    <= div_d;
      flags_q  <= flags_d;
    end
  end

  a_released_no_pticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pushed_q |-> (pticks_q == '0))
    else $error("pushed tick count nonzero while released");

  a_pushed_no_rticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pushed_q |-> (rticks_q == '0))
    else $error("released tick count nonzero while pushed");

  a_released_no_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pushed_q |-> (div_q == '0))
    else $error("repeat divider running while released");

endmodule

[design/button_gesture_classifier_core.sv]
// ----------------------------------------------------------------------------
// button_gesture_classifier_core
// Push-button click / press / long-press classifier with a pending event mask.
// ----------------------------------------------------------------------------
// One beat in is one tick; every beat gives exactly one result beat carrying
// the popped event code (zero when nothing is popped) and the pending mask
// left afterwards. A beat is registered on entry, classified by one pass of
// compare and counter logic and registered again at the output; one beat is
// taken every cycle while the output is not stalled. Configuration is written
// through cfg_we_i / cfg_index_i / cfg_data_i; the user must write it only
// while no beat is in flight, which the block itself does not enforce.
module button_gesture_classifier_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        pin_level_i,
  input  logic                        pop_event_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bgc_pkg::CodeBits-1:0] event_code_o,
  output bgc_pkg::events_t            pending_events_o,
  input  logic                        cfg_we_i,
  input  logic [bgc_pkg::IdxBits-1:0] cfg_index_i,
  input  bgc_pkg::cfg_word_t          cfg_data_i
);

  bgc_pkg::cfg_t    cfg;
  bgc_pkg::result_t res;

  logic             in_vld_q, in_vld_d;
  logic             pin_q, pop_q;
  logic             out_vld_q, out_vld_d;
  bgc_pkg::result_t out_q;
  logic             accept;
  logic             fire;

  bgc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bgc_tracker u_tracker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .pin_i  (pin_q),
    .pop_i  (pop_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_comb begin
    fire       = in_vld_q && (!out_vld_q || !out_stall_i);
    in_stall_o = in_vld_q && !fire;
    accept     = in_valid_i && !in_stall_o;
    in_vld_d   = accept || (in_vld_q && !fire);
    out_vld_d  = fire || (out_vld_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pin_q <= pin_level_i;
      pop_q <= pop_event_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign event_code_o     = out_q.code;
  assign pending_events_o = out_q.pending;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q)
    else $error("input stalled with an empty input register");

  a_fire_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("processed beat did not reach the output register");

  a_popped_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.code != bgc_pkg::EvNone)) |->
      !out_q.pending[out_q.code - bgc_pkg::EvClick])
    else $error("popped event still pending");

endmodule
